>>> src/pwfs_pkg.sv
// Package for the pulse-width frame sender: config types, register indexes, reset values.
package pwfs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_SLOT_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER_LIMIT   = 3'd5;

    localparam logic [7:0] RST_FRAME_PERIOD    = 8'd200;
    localparam logic [7:0] RST_HEADER_LIMIT    = 8'd20;
    localparam logic [3:0] RST_ONE_HIGH_LIMIT  = 4'd9;
    localparam logic [3:0] RST_ZERO_HIGH_LIMIT = 4'd5;
    localparam logic [3:0] RST_BIT_SLOT_LIMIT  = 4'd10;
    localparam logic [5:0] RST_TRAILER_LIMIT   = 6'd24;

    localparam logic [3:0] BITS_PER_FRAME = 4'd8;

    typedef struct packed {
        logic [7:0] frame_period;
        logic [7:0] header_limit;
        logic [3:0] one_high_limit;
        logic [3:0] zero_high_limit;
        logic [3:0] bit_slot_limit;
        logic [5:0] trailer_limit;
    } pwfs_cfg_t;

endpackage

>>> src/pwfs_core.sv
// Frame sequencer: period counter, header, bit slots and trailer for one tick per item.
module pwfs_core
    import pwfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] command_byte,
    input  pwfs_cfg_t  cfg,
    output logic       line_next,
    output logic       busy_next
);

    logic [7:0] period_count_reg, period_count_next;
    logic       sending_reg, sending_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [3:0] bits_left_reg, bits_left_next;
    logic [7:0] header_count_reg, header_count_next;
    logic [3:0] one_slot_reg, one_slot_next;
    logic [3:0] zero_slot_reg, zero_slot_next;
    logic [5:0] trailer_count_reg, trailer_count_next;
    logic       line_reg, line_reg_next;

    logic [7:0] period_inc;
    logic       latch;
    logic       bit_one;
    logic [3:0] slot_inc;
    logic [3:0] high_limit;
    logic [3:0] slot_new;

    always_comb begin
        period_inc         = period_count_reg + 8'd1;
        latch              = (period_inc == cfg.frame_period);
        period_count_next  = latch ? 8'd0 : period_inc;
        sending_next       = sending_reg | latch;
        shift_byte_next    = latch ? command_byte : shift_byte_reg;
        bits_left_next     = bits_left_reg;
        header_count_next  = header_count_reg;
        one_slot_next      = one_slot_reg;
        zero_slot_next     = zero_slot_reg;
        trailer_count_next = trailer_count_reg;
        line_reg_next      = line_reg;

        bit_one    = shift_byte_next[7];
        slot_inc   = (bit_one ? one_slot_reg : zero_slot_reg) + 4'd1;
        high_limit = bit_one ? cfg.one_high_limit : cfg.zero_high_limit;
        slot_new   = slot_inc;

        if (sending_next) begin
            header_count_next = header_count_reg + 8'd1;
            if (header_count_next < cfg.header_limit) begin
                line_reg_next = 1'b0;
            end else if (bits_left_reg != 4'd0) begin
                if (slot_inc < high_limit) begin
                    line_reg_next = 1'b1;
                end else if (slot_inc < cfg.bit_slot_limit) begin
                    line_reg_next = 1'b0;
                end else begin
                    slot_new        = 4'd0;
                    shift_byte_next = {shift_byte_next[6:0], 1'b0};
                    bits_left_next  = bits_left_reg - 4'd1;
                end
                if (bit_one) begin
                    one_slot_next = slot_new;
                end else begin
                    zero_slot_next = slot_new;
                end
            end else begin
                trailer_count_next = trailer_count_reg + 6'd1;
                line_reg_next      = 1'b0;
                if (trailer_count_next == cfg.trailer_limit) begin
                    line_reg_next      = 1'b1;
                    bits_left_next     = BITS_PER_FRAME;
                    sending_next       = 1'b0;
                    header_count_next  = 8'd0;
                    trailer_count_next = 6'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_count_reg  <= 8'd0;
            sending_reg       <= 1'b0;
            shift_byte_reg    <= 8'd0;
            bits_left_reg     <= BITS_PER_FRAME;
            header_count_reg  <= 8'd0;
            one_slot_reg      <= 4'd0;
            zero_slot_reg     <= 4'd0;
            trailer_count_reg <= 6'd0;
            line_reg          <= 1'b1;
        end else if (step) begin
            period_count_reg  <= period_count_next;
            sending_reg       <= sending_next;
            shift_byte_reg    <= shift_byte_next;
            bits_left_reg     <= bits_left_next;
            header_count_reg  <= header_count_next;
            one_slot_reg      <= one_slot_next;
            zero_slot_reg     <= zero_slot_next;
            trailer_count_reg <= trailer_count_next;
            line_reg          <= line_reg_next;
        end
    end

    assign line_next = line_reg_next;
    assign busy_next = sending_next;

endmodule

>>> src/pulse_width_frame_sender.sv
// Top level of the pulse-width frame sender: config registers, tick stream, result register.
//
// Each input item is one tick carrying the current command byte; each tick gives exactly
// one result item holding the line level and the busy flag after that tick. Every frame
// period the command byte is latched and a frame starts: a low header, eight bits MSB
// first as pulse-width slots, then a low trailer that ends with the line back at its idle
// high level. A tick is taken and the result register reloaded in each clock cycle in which
// that register is empty or being taken, so the rate is one item per cycle unless the output
// stalls; the sequencer counters step on each tick, and the result is registered.
// Configuration is always ready; writes to indexes past the last register are ignored.
module pulse_width_frame_sender
    import pwfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] command_byte

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,    // [0] line_level, [1] busy_res, [7:2] zero

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pwfs_cfg_t cfg_reg;
    logic      m_tvalid_reg;
    logic      line_level_reg;
    logic      busy_res_reg;
    logic      step;
    logic      line_next;
    logic      busy_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign step      = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_period    <= RST_FRAME_PERIOD;
            cfg_reg.header_limit    <= RST_HEADER_LIMIT;
            cfg_reg.one_high_limit  <= RST_ONE_HIGH_LIMIT;
            cfg_reg.zero_high_limit <= RST_ZERO_HIGH_LIMIT;
            cfg_reg.bit_slot_limit  <= RST_BIT_SLOT_LIMIT;
            cfg_reg.trailer_limit   <= RST_TRAILER_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FRAME_PERIOD:    cfg_reg.frame_period    <= cfg_data;
                REG_HEADER_LIMIT:    cfg_reg.header_limit    <= cfg_data;
                REG_ONE_HIGH_LIMIT:  cfg_reg.one_high_limit  <= cfg_data[3:0];
                REG_ZERO_HIGH_LIMIT: cfg_reg.zero_high_limit <= cfg_data[3:0];
                REG_BIT_SLOT_LIMIT:  cfg_reg.bit_slot_limit  <= cfg_data[3:0];
                REG_TRAILER_LIMIT:   cfg_reg.trailer_limit   <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    pwfs_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .command_byte (s_tdata),
        .cfg          (cfg_reg),
        .line_next    (line_next),
        .busy_next    (busy_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            line_level_reg <= line_next;
            busy_res_reg   <= busy_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, busy_res_reg, line_level_reg};

endmodule
